FILE: hw/rtl/rotation_to_xyz_fixed_angles_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-angle extraction block.
// ----------------------------------------------------------------------------
`ifndef ROTATION_TO_XYZ_FIXED_ANGLES_ASSERT_SVH
`define ROTATION_TO_XYZ_FIXED_ANGLES_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RXFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RXFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/rxfa_pkg.sv
// ----------------------------------------------------------------------------
// rxfa_pkg
// Shared types, constants and the arctangent table of the angle extractor.
// ----------------------------------------------------------------------------
`default_nettype none
package rxfa_pkg;

	localparam int CordicStagesDefault = 16;
	localparam int SampleWidthDefault  = 16;
	localparam int AngW    = 34;
	localparam int AngOutW = 16;
	localparam int TolW    = 15;
	localparam int InvGainQ20 = 636750;
	localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
	localparam logic signed [AngOutW-1:0] PiQ13     = 16'sd25736;
	localparam logic signed [AngOutW-1:0] HalfPiQ13 = 16'sd12868;
	localparam logic [1:0] AddrTol = 2'd0;

	typedef struct packed {
		logic signed [15:0] r11;
		logic signed [15:0] r21;
		logic signed [15:0] r31;
		logic signed [15:0] r12;
		logic signed [15:0] r22;
		logic signed [15:0] r32;
		logic signed [15:0] r33;
	} rxfa_in_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic               gimbal_lock;
	} rxfa_out_t;

	// Stage arctangent, Q30, rounded to nearest.
	function automatic logic signed [AngW-1:0] atan_q30(input int idx);
		logic [31:0] v;
		begin
			case (idx)
				0: v = 32'd843314857;
				1: v = 32'd497837829;
				2: v = 32'd263043837;
				3: v = 32'd133525159;
				4: v = 32'd67021687;
				5: v = 32'd33543516;
				6: v = 32'd16775851;
				7: v = 32'd8388437;
				8: v = 32'd4194283;
				9: v = 32'd2097149;
				default: v = (idx <= 30) ? (32'd1 << (30 - idx)) : 32'd0;
			endcase
			return AngW'(signed'({1'b0, v}));
		end
	endfunction

	// Q30 angle to saturated Q13.
	function automatic logic signed [AngOutW-1:0] to_q13(input logic signed [AngW-1:0] z);
		logic signed [AngW:0] s;
		logic signed [AngW-17:0] a;
		begin
			s = {z[AngW-1], z} + (AngW+1)'(65536);
			a = s[AngW:17];
			if (a > (AngW-16)'(signed'(PiQ13)))
				return PiQ13;
			else if (a < -(AngW-16)'(signed'(PiQ13)))
				return -PiQ13;
			else
				return a[AngOutW-1:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rotation_to_xyz_fixed_angles.sv
// ----------------------------------------------------------------------------
// rotation_to_xyz_fixed_angles
// Extracts roll, pitch and yaw (XYZ fixed angles) from rotation-matrix entries.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries seven Q2.14 matrix entries per transfer; the
//   output channel carries roll, pitch, yaw (Q3.13 radians) and a gimbal-lock
//   flag. Both channels use valid/stall handshakes.
//   The tolerance register (APB, address 0) selects the gimbal-lock branch.
//   Throughput: one transfer per cycle while the output is not stalled.
//   The data path is two CORDIC pipelines in series (yaw/magnitude, then pitch),
//   the gain-correction product and rounding registers and the output register.
//   The whole pipeline advances together; when the receiver stalls a full
//   output register, every stage holds and the input is stalled, so nothing
//   is lost or repeated. A bubble in the pipeline still moves forward.
//   Reset clears the valid bits and sets the tolerance to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_to_xyz_fixed_angles #(
	parameter int CORDIC_STAGES = rxfa_pkg::CordicStagesDefault,
	parameter int SAMPLE_WIDTH  = rxfa_pkg::SampleWidthDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire rxfa_pkg::rxfa_in_t in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output rxfa_pkg::rxfa_out_t out_data,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire [1:0]           paddr,
	input  wire [31:0]          pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import rxfa_pkg::*;

	localparam int XW    = SAMPLE_WIDTH + 8 + 4;
	localparam int LAT1  = CORDIC_STAGES + 1;
	localparam int DEPTH = 2 * LAT1 + 3;

	logic [TolW-1:0] tol_q;
	logic            adv;
	logic            valid_q [DEPTH];

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && paddr == AddrTol) begin
			tol_q <= pwdata[TolW-1:0];
		end
	end
	assign prdata = (paddr == AddrTol) ? {{(32-TolW){1'b0}}, tol_q} : '0;

	// The pipeline advances when the output slot is free or being taken.
	assign adv      = !valid_q[DEPTH-1] || !out_stall;
	assign in_stall = !adv;

	// Sample extension from the low SAMPLE_WIDTH bits, with guard bits.
	function automatic logic signed [XW-1:0] samp(input logic [15:0] r);
		logic signed [SAMPLE_WIDTH-1:0] s;
		begin
			s = SAMPLE_WIDTH'(signed'(r));
			return XW'(s) <<< 8;
		end
	endfunction

	logic signed [XW-1:0] e11, e21, e31, e12, e22, e32, e33;
	logic signed [XW-1:0] a11, a21;
	logic                 lock_in;
	assign e11 = samp(in_data.r11);
	assign e21 = samp(in_data.r21);
	assign e31 = samp(in_data.r31);
	assign e12 = samp(in_data.r12);
	assign e22 = samp(in_data.r22);
	assign e32 = samp(in_data.r32);
	assign e33 = samp(in_data.r33);
	assign a11 = (e11 < 0) ? -e11 : e11;
	assign a21 = (e21 < 0) ? -e21 : e21;
	assign lock_in = (a11 <= (XW'(tol_q) <<< 8)) && (a21 <= (XW'(tol_q) <<< 8));

	// Roll CORDIC: (r33, r32) or at gimbal lock (r22, r12).
	logic signed [XW-1:0]   roll_mag, yaw_mag, pitch_mag;
	logic signed [AngW-1:0] roll_z, yaw_z, pitch_z;

	rxfa_cordic #(.STAGES(CORDIC_STAGES), .XW(XW)) u_roll (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.x_in(lock_in ? e22 : e33), .y_in(lock_in ? e12 : e32),
		.mag(roll_mag), .ang(roll_z)
	);

	// Yaw and magnitude CORDIC.
	rxfa_cordic #(.STAGES(CORDIC_STAGES), .XW(XW)) u_yaw (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.x_in(e11), .y_in(e21), .mag(yaw_mag), .ang(yaw_z)
	);

	// Side data delay line up to the end of the first CORDIC.
	logic signed [XW-1:0] nr31_d [LAT1];
	logic                 lock_d [LAT1];
	always_ff @(posedge clk) begin
		if (adv) begin
			nr31_d[0] <= -e31;
			lock_d[0] <= lock_in;
			for (int i = 1; i < LAT1; i++) begin
				nr31_d[i] <= nr31_d[i-1];
				lock_d[i] <= lock_d[i-1];
			end
		end
	end

	// Gain correction: product registered, then rounded.
	logic signed [XW+21:0]   prod_s1;
	logic signed [XW-1:0]    nr31_s1;
	logic                    lock_s1;
	logic signed [AngOutW-1:0] roll_s1, yaw_s1;
	logic signed [XW-1:0]    hm_s2, nr31_s2;
	logic                    lock_s2;
	logic signed [AngOutW-1:0] roll_s2, yaw_s2;
	logic signed [XW+21:0]   rnd;
	assign rnd = prod_s1 + (XW+22)'(1 <<< 19);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= (XW+22)'(yaw_mag) * (XW+22)'(InvGainQ20);
			nr31_s1 <= nr31_d[LAT1-1];
			lock_s1 <= lock_d[LAT1-1];
			yaw_s1  <= to_q13(yaw_z);
			roll_s1 <= to_q13(roll_z);
			hm_s2   <= rnd[XW+19:20];
			nr31_s2 <= nr31_s1;
			lock_s2 <= lock_s1;
			yaw_s2  <= yaw_s1;
			roll_s2 <= roll_s1;
		end
	end

	// Pitch CORDIC.
	rxfa_cordic #(.STAGES(CORDIC_STAGES), .XW(XW)) u_pitch (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.x_in(hm_s2), .y_in(nr31_s2), .mag(pitch_mag), .ang(pitch_z)
	);

	// Roll, yaw and lock wait for the pitch result.
	logic signed [AngOutW-1:0] roll_d [LAT1];
	logic signed [AngOutW-1:0] yaw_d  [LAT1];
	logic                      lk_d   [LAT1];
	logic                      hold_roll;
	assign hold_roll = roll_mag[0] ^ yaw_mag[0] ^ pitch_mag[0];
	always_ff @(posedge clk) begin
		if (adv) begin
			roll_d[0] <= roll_s2;
			yaw_d[0]  <= yaw_s2;
			lk_d[0]   <= lock_s2;
			for (int i = 1; i < LAT1; i++) begin
				roll_d[i] <= roll_d[i-1];
				yaw_d[i]  <= yaw_d[i-1];
				lk_d[i]   <= lk_d[i-1];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.roll_angle  <= roll_d[LAT1-1];
			out_data.gimbal_lock <= lk_d[LAT1-1];
			out_data.pitch_angle <= lk_d[LAT1-1] ? HalfPiQ13 : to_q13(pitch_z);
			out_data.yaw_angle   <= lk_d[LAT1-1] ? '0 : yaw_d[LAT1-1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) valid_q[i] <= 1'b0;
		end else if (adv) begin
			valid_q[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) valid_q[i] <= valid_q[i-1];
		end
	end
	assign out_valid = valid_q[DEPTH-1];

	logic unused_ok;
	assign unused_ok = hold_roll ^ pwdata[31];

	`include "rotation_to_xyz_fixed_angles_assert.svh"

	`RXFA_ASSERT_IMPL(a_stall_only_full, clk, arst_n, in_stall, out_valid && out_stall)
	`RXFA_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, out_valid && out_stall, out_valid)
	`RXFA_ASSERT_IMPL(a_lock_pitch, clk, arst_n, out_valid && out_data.gimbal_lock,
		out_data.pitch_angle == HalfPiQ13 && out_data.yaw_angle == 0)
endmodule
`default_nettype wire

FILE: hw/rtl/rxfa_cordic.sv
// ----------------------------------------------------------------------------
// rxfa_cordic
// Pipelined vectoring CORDIC: a pre-rotation register, then one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rxfa_cordic #(
	parameter int STAGES = 16,
	parameter int XW     = 28
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire signed [XW-1:0]  x_in,
	input  wire signed [XW-1:0]  y_in,
	output logic signed [XW-1:0] mag,
	output logic signed [rxfa_pkg::AngW-1:0] ang
);
	import rxfa_pkg::*;

	logic signed [XW-1:0]   x_q [STAGES+1];
	logic signed [XW-1:0]   y_q [STAGES+1];
	logic signed [AngW-1:0] z_q [STAGES+1];
	logic                   zero_q [STAGES+1];
	logic signed [XW-1:0]   px, py;
	logic signed [AngW-1:0] pz;

	// Pre-rotation by quarter turn so that x is not negative.
	always_comb begin
		px = x_in;
		py = y_in;
		pz = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				px = y_in; py = -x_in; pz = HalfPiQ30;
			end else begin
				px = -y_in; py = x_in; pz = -HalfPiQ30;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= px;
			y_q[0] <= py;
			z_q[0] <= pz;
			zero_q[0] <= (x_in == 0) && (y_in == 0);
		end
	end

	// Micro-rotation stages.
	for (genvar i = 0; i < STAGES; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
				if (y_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_q30(i);
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_q30(i);
				end
			end
		end
	end

	assign mag = zero_q[STAGES] ? '0 : x_q[STAGES];
	assign ang = zero_q[STAGES] ? '0 : z_q[STAGES];

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule
`default_nettype wire

FILE: bench/rotation_to_xyz_fixed_angles_test.sv
// ----------------------------------------------------------------------------
// rotation_to_xyz_fixed_angles_test
// Self-checking bench for the XYZ fixed-angle extractor. Matrix entries are
// pushed through the valid/stall input channel in phases of input idling and
// receiver stalls, each under its set gimbal-lock tolerance. Each result is compared
// field by field with typed-in angles or the bit-exact CORDIC angle predictor here.
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_to_xyz_fixed_angles_test;
	import rxfa_pkg::*;

	localparam int StageCount = 16;
	localparam int DrainCycles = 2 * (StageCount + 1) + 4 + 8;
	localparam int WatchdogLimit = 4000;
	localparam longint HalfPiRad = 64'sd1686629713;
	localparam longint GuardScale = 256;
	localparam longint ArctanQ30 [0:15] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768
	};

	typedef struct {
		rxfa_in_t  mat;
		bit        typed;
		rxfa_out_t angles;
	} matrix_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	rxfa_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	rxfa_out_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rxfa_out_t   angle_queue[$];
	longint      tolerance;
	int          send_idle_pct;
	int          stall_pct;
	int          quiet_cycles;
	bit          failed;

	rotation_to_xyz_fixed_angles i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Vectoring CORDIC: returns the angle of (x, y) in Q30 and the gained magnitude.
	function automatic longint vector_angle(input longint xi, input longint yi,
			output longint mag);
		longint x, y, z, t, xs, ys;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		// Pre-rotate by a quarter turn so that x is not negative.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HalfPiRad;
			end else begin
				x = -y;
				y = t;
				z = -HalfPiRad;
			end
		end
		for (int i = 0; i < StageCount; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ArctanQ30[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ArctanQ30[i];
			end
		end
		mag = x;
		return z;
	endfunction

	// Rounds a Q30 angle to Q13 and saturates it at plus or minus pi.
	function automatic longint angle_q13(input longint z);
		longint a;
		a = (z + 65536) >>> 17;
		if (a > 25736)
			a = 25736;
		if (a < -25736)
			a = -25736;
		return a;
	endfunction

	// Expected roll, pitch, yaw and lock flag for one matrix.
	function automatic rxfa_out_t predict_angles(input rxfa_in_t m);
		rxfa_out_t o;
		longint a11, a21, gm, hm, unused;
		a11 = (m.r11 < 0) ? -longint'(m.r11) : longint'(m.r11);
		a21 = (m.r21 < 0) ? -longint'(m.r21) : longint'(m.r21);
		if (a11 > tolerance || a21 > tolerance) begin
			o.yaw_angle = 16'(angle_q13(vector_angle(longint'(m.r11) * GuardScale,
				longint'(m.r21) * GuardScale, gm)));
			hm = (gm * InvGainQ20 + (64'sd1 << 19)) >>> 20;
			o.pitch_angle = 16'(angle_q13(vector_angle(hm,
				-longint'(m.r31) * GuardScale, unused)));
			o.roll_angle = 16'(angle_q13(vector_angle(longint'(m.r33) * GuardScale,
				longint'(m.r32) * GuardScale, unused)));
			o.gimbal_lock = 1'b0;
		end else begin
			o.pitch_angle = HalfPiQ13;
			o.yaw_angle = '0;
			o.roll_angle = 16'(angle_q13(vector_angle(longint'(m.r22) * GuardScale,
				longint'(m.r12) * GuardScale, unused)));
			o.gimbal_lock = 1'b1;
		end
		return o;
	endfunction

	function automatic rxfa_in_t make_matrix(input int a, input int b, input int c,
			input int d, input int e, input int f, input int g);
		rxfa_in_t m;
		m.r11 = 16'(a);
		m.r21 = 16'(b);
		m.r31 = 16'(c);
		m.r12 = 16'(d);
		m.r22 = 16'(e);
		m.r32 = 16'(f);
		m.r33 = 16'(g);
		return m;
	endfunction

	// Random matrix; many have r11 and r21 near the tolerance to probe the lock branch.
	function automatic rxfa_in_t random_matrix();
		rxfa_in_t m;
		int span;
		m = $bits(rxfa_in_t)'({$urandom, $urandom, $urandom, $urandom});
		span = int'(tolerance) + 2;
		if ($urandom_range(99) < 40) begin
			m.r11 = 16'($urandom_range(2 * span) - span);
			m.r21 = 16'($urandom_range(2 * span) - span);
		end
		if ($urandom_range(99) < 10) begin
			m.r32 = '0;
			m.r12 = '0;
		end
		if ($urandom_range(99) < 10) begin
			m.r33 = '0;
			m.r22 = '0;
		end
		return m;
	endfunction

	// One input transfer; the expectation is queued at the accepting edge.
	task automatic send_matrix(input rxfa_in_t m, input bit typed, input rxfa_out_t e);
		in_valid <= 1'b1;
		in_data <= m;
		do @(posedge clk); while (in_stall);
		angle_queue.push_back(typed ? e : predict_angles(m));
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Register write followed by a read-back check.
	task automatic write_tolerance(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrTol;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[TolW-1:0] !== value[TolW-1:0]) begin
			$display("%0t: tolerance read expected %0d actual %0d", $time,
				value[TolW-1:0], prdata[TolW-1:0]);
			failed = 1'b1;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		tolerance = longint'(value & 32'h7FFF);
	endtask

	// Waits until every expected result has arrived, then lets the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (angle_queue.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int e, input int a);
		if (e != a) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, e, a);
			failed = 1'b1;
		end
	endtask

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		rxfa_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (angle_queue.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h", $time, out_data);
				failed = 1'b1;
			end else begin
				e = angle_queue.pop_front();
				check_field("roll_angle", e.roll_angle, out_data.roll_angle);
				check_field("pitch_angle", e.pitch_angle, out_data.pitch_angle);
				check_field("yaw_angle", e.yaw_angle, out_data.yaw_angle);
				check_field("gimbal_lock", e.gimbal_lock, out_data.gimbal_lock);
			end
		end
	end

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog on cycles with no transfer on either channel or the register port.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus: directed table, then random phases under several tolerances.
	initial begin
		matrix_row_t rows[$];
		matrix_row_t r;
		rxfa_out_t locked_zero;
		rxfa_out_t none;
		int phase_idle[4];
		int phase_stall[4];
		logic [31:0] phase_tol[4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		failed = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		tolerance = 0;
		none = '0;
		locked_zero.roll_angle = '0;
		locked_zero.pitch_angle = HalfPiQ13;
		locked_zero.yaw_angle = '0;
		locked_zero.gimbal_lock = 1'b1;

		// Matrices with expected angles typed in where they are plain to see.
		r = '{make_matrix(0, 0, 0, 0, 0, 0, 0), 1'b1, locked_zero}; rows.push_back(r);
		r = '{make_matrix(0, 0, 32767, 0, 0, -32768, 32767), 1'b1, locked_zero};
		rows.push_back(r);
		r = '{make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0, none};
		rows.push_back(r);
		r = '{make_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 1'b0,
			none};
		rows.push_back(r);
		r = '{make_matrix(16384, 0, 0, 0, 16384, 0, 16384), 1'b0, none}; rows.push_back(r);
		r = '{make_matrix(-16384, 0, 0, 0, -16384, 0, -16384), 1'b0, none};
		rows.push_back(r);
		r = '{make_matrix(-32768, 0, -32768, 0, 0, 0, -32768), 1'b0, none};
		rows.push_back(r);
		r = '{make_matrix(-32768, -1, 32767, 0, 0, -1, -32768), 1'b0, none};
		rows.push_back(r);
		r = '{make_matrix(0, 16384, 16384, -16384, 0, 16384, 0), 1'b0, none};
		rows.push_back(r);
		r = '{make_matrix(0, -16384, -16384, 0, 0, -16384, 0), 1'b0, none};
		rows.push_back(r);
		r = '{make_matrix(1, 0, -32768, 0, 0, 0, 1), 1'b0, none}; rows.push_back(r);
		r = '{make_matrix(0, 0, 0, 0, -16384, 0, 0), 1'b0, none}; rows.push_back(r);
		r = '{make_matrix(0, 0, 0, -32768, -32768, 0, 0), 1'b0, none}; rows.push_back(r);
		r = '{make_matrix(0, 0, 0, 16384, 0, 0, 0), 1'b0, none}; rows.push_back(r);
		r = '{make_matrix(11585, 11585, -11585, -11585, 11585, 8192, 8192), 1'b0, none};
		rows.push_back(r);
		r = '{make_matrix(0, 1, 0, 0, 0, 0, 0), 1'b0, none}; rows.push_back(r);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_tolerance(32'd0);

		foreach (rows[i])
			send_matrix(rows[i].mat, rows[i].typed, rows[i].angles);
		drain();

		phase_idle = '{0, 78, 0, 28};
		phase_stall = '{0, 0, 78, 28};
		phase_tol = '{32'd16384, 32'd32767, $urandom_range(400), 32'd0};
		for (int p = 0; p < 4; p++) begin
			write_tolerance(phase_tol[p]);
			send_idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < 125; n++)
				send_matrix(random_matrix(), 1'b0, none);
			drain();
		end
		stall_pct = 0;
		repeat (DrainCycles) @(posedge clk);

		if (failed || angle_queue.size() != 0)
			$display("Some tests failed");
		else
			$display("All tests passed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: rotation_to_xyz_fixed_angles.f
+incdir+hw/rtl
hw/rtl/rxfa_pkg.sv
hw/rtl/rxfa_cordic.sv
hw/rtl/rotation_to_xyz_fixed_angles.sv
bench/rotation_to_xyz_fixed_angles_test.sv
